### src/latched_chr_bank_mapper_defines.svh
// Assertion macros shared by the latched CHR bank mapper RTL.
`ifndef LATCHED_CHR_BANK_MAPPER_DEFINES_SVH
`define LATCHED_CHR_BANK_MAPPER_DEFINES_SVH

// Same-cycle implication, checked at every clk edge outside reset.
`define LCBM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcbm assertion failed");

// Next-cycle implication, checked at every clk edge outside reset.
`define LCBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcbm assertion failed");

`endif

### src/lcbm_pkg.sv
// Package with types, constants and helpers of the latched CHR bank mapper.
`timescale 1ns / 1ps
`default_nettype none
package lcbm_pkg;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int COUNT_W    = 5;
  localparam int NUM_BANKS  = 6;
  localparam int BANK_IDX_W = 3;

  // register index of the configuration port
  localparam logic REG_PRG_BANK_COUNT = 1'b0;

  localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] PRG_COUNT_MIN   = 5'd4;
  localparam logic [COUNT_W-1:0] PRG_COUNT_MAX   = 5'd16;

  // bank register roles
  localparam logic [BANK_IDX_W-1:0] BANK_PRG    = 3'd0;
  localparam logic [BANK_IDX_W-1:0] BANK_CHR_LO = 3'd1;
  localparam logic [BANK_IDX_W-1:0] BANK_MIRROR = 3'd5;

  localparam logic [3:0] BANK_WIN_BASE = 4'hA;
  localparam logic [7:0] TILE_FD       = 8'hFD;
  localparam logic [7:0] TILE_FE       = 8'hFE;

  typedef enum logic [1:0] {
    OP_CPU_RD = 2'd0,
    OP_CPU_WR = 2'd1,
    OP_PPU_RD = 2'd2,
    OP_PPU_WR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REGION_PRG_RAM = 2'd0,
    REGION_PRG_ROM = 2'd1,
    REGION_CHR     = 2'd2,
    REGION_NT      = 2'd3
  } region_t;

  typedef logic [NUM_BANKS-1:0][7:0] bank_file_t;

  typedef struct packed {
    logic                  bank_we;
    logic [BANK_IDX_W-1:0] bank_idx;
    logic [7:0]            bank_data;
    logic                  latch_we;
    logic                  latch_half;
    logic                  latch_val;
  } state_upd_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  region;
    logic [16:0] offset;
  } xlate_res_t;

  // Switched bank modulo the bank count: bank < 16 and count >= 4,
  // so three conditional subtracts always land below count.
  function automatic logic [3:0] prg_bank_wrap(input logic [3:0] bank,
                                               input logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0] v;
    v = {1'b0, bank};
    for (int i = 0; i < 3; i++) begin
      if (v >= count) begin
        v = v - count;
      end
    end
    return v[3:0];
  endfunction

endpackage
`default_nettype wire

### src/lcbm_req_if.sv
// Bus access channel interface: valid/ready plus op, addr and data.
`timescale 1ns / 1ps
`default_nettype none
interface lcbm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] addr;
  logic [7:0]  data;

  modport source (output valid, output op, output addr, output data, input ready);
  modport sink (input valid, input op, input addr, input data, output ready);
endinterface
`default_nettype wire

### src/lcbm_rsp_if.sv
// Translation result channel interface: valid/ready plus hit, region and offset.
`timescale 1ns / 1ps
`default_nettype none
interface lcbm_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  region;
  logic [16:0] offset;

  modport source (output valid, output hit, output region, output offset, input ready);
  modport sink (input valid, input hit, input region, input offset, output ready);
endinterface
`default_nettype wire

### src/lcbm_apb.sv
// APB configuration register holding the PRG bank count.
`timescale 1ns / 1ps
`default_nettype none
module lcbm_apb (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lcbm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [lcbm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [lcbm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output logic      [lcbm_pkg::COUNT_W-1:0]        count_eff
);

  logic [lcbm_pkg::COUNT_W-1:0] prg_bank_count;
  logic                         sel_count;

  assign pready    = 1'b1;
  assign sel_count = (paddr[2] == lcbm_pkg::REG_PRG_BANK_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= lcbm_pkg::PRG_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && sel_count) begin
      prg_bank_count <= pwdata[lcbm_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_count) begin
      prdata = {{(lcbm_pkg::APB_DATA_W-lcbm_pkg::COUNT_W){1'b0}}, prg_bank_count};
    end
  end

  // clamp into the supported 4..16 range
  always_comb begin
    if (prg_bank_count < lcbm_pkg::PRG_COUNT_MIN) begin
      count_eff = lcbm_pkg::PRG_COUNT_MIN;
    end else if (prg_bank_count > lcbm_pkg::PRG_COUNT_MAX) begin
      count_eff = lcbm_pkg::PRG_COUNT_MAX;
    end else begin
      count_eff = prg_bank_count;
    end
  end

endmodule
`default_nettype wire

### src/lcbm_bank_state.sv
// Bank registers and CHR tile latches, written only by translated accesses.
`timescale 1ns / 1ps
`default_nettype none
module lcbm_bank_state (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lcbm_pkg::state_upd_t upd,
  output lcbm_pkg::bank_file_t      bank_regs,
  output logic [1:0]                latches
);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_regs <= '0;
      latches   <= '0;
    end else begin
      if (upd.bank_we) begin
        bank_regs[upd.bank_idx] <= upd.bank_data;
      end
      if (upd.latch_we) begin
        latches[upd.latch_half] <= upd.latch_val;
      end
    end
  end

endmodule
`default_nettype wire

### src/lcbm_xlate.sv
// Address decode: region, offset and state update for one bus access.
`timescale 1ns / 1ps
`default_nettype none
module lcbm_xlate (
  input  wire logic                            fire,
  input  wire logic [1:0]                      op,
  input  wire logic [15:0]                     addr,
  input  wire logic [7:0]                      data,
  input  wire logic [lcbm_pkg::COUNT_W-1:0]    count_eff,
  input  wire lcbm_pkg::bank_file_t            bank_regs,
  input  wire logic [1:0]                      latches,
  output lcbm_pkg::xlate_res_t                 res,
  output lcbm_pkg::state_upd_t                 upd
);

  logic                                is_cpu;
  logic                                half;
  logic [lcbm_pkg::BANK_IDX_W-1:0]     chr_idx;
  logic [7:0]                          chr_reg;
  logic [3:0]                          prg_sw_bank;
  logic [lcbm_pkg::COUNT_W:0]          fixed_sum;
  logic [3:0]                          fixed_bank;
  logic [3:0]                          win_idx;
  logic                                nt_second;
  logic [7:0]                          tile;

  assign is_cpu  = (op == lcbm_pkg::OP_CPU_RD) || (op == lcbm_pkg::OP_CPU_WR);
  assign half    = addr[12];
  assign chr_idx = lcbm_pkg::BANK_CHR_LO + {1'b0, half, 1'b0} + {2'b00, latches[half]};
  assign chr_reg = bank_regs[chr_idx];
  assign tile    = addr[11:4];

  assign prg_sw_bank = lcbm_pkg::prg_bank_wrap(bank_regs[lcbm_pkg::BANK_PRG][3:0], count_eff);
  // $A000 -> count-3, $C000 -> count-2, $E000 -> count-1
  assign fixed_sum  = {1'b0, count_eff} + {3'b000, addr[15:13]} - 6'd8;
  assign fixed_bank = fixed_sum[3:0];
  assign win_idx    = addr[15:12] - lcbm_pkg::BANK_WIN_BASE;

  // horizontal when bit 0 set: second table for $2800 and up
  assign nt_second = bank_regs[lcbm_pkg::BANK_MIRROR][0] ? addr[11] : addr[10];

  always_comb begin
    res = '0;
    if (is_cpu) begin
      if (addr[15:13] == 3'b011) begin
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_PRG_RAM;
        res.offset = {4'b0000, addr[12:0]};
      end else if (addr[15:13] == 3'b100) begin
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_PRG_ROM;
        res.offset = {prg_sw_bank, addr[12:0]};
      end else if (addr >= 16'hA000) begin
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_PRG_ROM;
        res.offset = {fixed_bank, addr[12:0]};
      end
    end else begin
      if (addr[15:13] == 3'b000) begin
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_CHR;
        res.offset = {chr_reg[4:0], addr[11:0]};
      end else if (addr[15:12] == 4'h2) begin
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_NT;
        res.offset = {6'b000000, nt_second, addr[9:0]};
      end
    end
  end

  always_comb begin
    upd            = '0;
    upd.bank_idx   = win_idx[lcbm_pkg::BANK_IDX_W-1:0];
    upd.bank_data  = data;
    upd.latch_half = half;
    upd.latch_val  = (tile == lcbm_pkg::TILE_FE);
    upd.bank_we    = fire && (op == lcbm_pkg::OP_CPU_WR) && (addr >= 16'hA000);
    upd.latch_we   = fire && (op == lcbm_pkg::OP_PPU_RD) && (addr[15:13] == 3'b000)
                     && ((tile == lcbm_pkg::TILE_FD) || (tile == lcbm_pkg::TILE_FE));
  end

endmodule
`default_nettype wire

### src/latched_chr_bank_mapper.sv
// Top level of the latched CHR bank mapper: access stage, decode, result register.
// An access taken on req is staged, then decoded into the result register on rsp.
// Throughput: one access per clock; the access stage and the result register
//   form a two-entry pipeline, so req stays ready while rsp is taken each cycle.
// Reset (rst, synchronous): clears bank registers, tile latches and both valid
//   flags, and sets the PRG bank count to 16.
`timescale 1ns / 1ps
`default_nettype none
`include "latched_chr_bank_mapper_defines.svh"
module latched_chr_bank_mapper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lcbm_req_if.sink                             req,
  lcbm_rsp_if.source                           rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lcbm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lcbm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lcbm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  // access stage (input register)
  logic        acc_valid;
  logic [1:0]  acc_op;
  logic [15:0] acc_addr;
  logic [7:0]  acc_data;

  // result register
  logic        res_valid;
  lcbm_pkg::xlate_res_t res_q;

  logic                           advance;
  logic [lcbm_pkg::COUNT_W-1:0]   count_eff;
  lcbm_pkg::bank_file_t           bank_regs;
  logic [1:0]                     latches;
  lcbm_pkg::xlate_res_t           res_d;
  lcbm_pkg::state_upd_t           upd;

  // Move the staged access into the result register when that slot is free
  // or being drained this cycle. State updates ride on the same edge, so the
  // next staged access already sees them.
  assign advance   = acc_valid && (!res_valid || rsp.ready);
  assign req.ready = !acc_valid || advance;

  lcbm_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .count_eff (count_eff)
  );

  lcbm_bank_state u_state (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .bank_regs (bank_regs),
    .latches   (latches)
  );

  // Decode reads the state from before this access's own update.
  lcbm_xlate u_xlate (
    .fire      (advance),
    .op        (acc_op),
    .addr      (acc_addr),
    .data      (acc_data),
    .count_eff (count_eff),
    .bank_regs (bank_regs),
    .latches   (latches),
    .res       (res_d),
    .upd       (upd)
  );

  // Hold the access stage until it advances; load on each req transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (req.ready) begin
      acc_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      acc_op   <= req.op;
      acc_addr <= req.addr;
      acc_data <= req.data;
    end
  end

  // Result register: drop when taken, refill on advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid  = res_valid;
  assign rsp.hit    = res_q.hit;
  assign rsp.region = res_q.region;
  assign rsp.offset = res_q.offset;

  // A miss always reports region zero and offset zero.
  `LCBM_ASSERT_IMPL(a_miss_zero, rsp.valid && !rsp.hit, rsp.region == 2'd0 && rsp.offset == 17'd0)
  // A staged access that cannot advance must still be staged next cycle.
  `LCBM_ASSERT_NEXT(a_stage_hold, acc_valid && !advance, acc_valid)
  // An empty access stage never stalls the request side.
  `LCBM_ASSERT_IMPL(a_ready_when_empty, !acc_valid, req.ready)
  // PRG RAM offsets stay inside the 8KB window.
  `LCBM_ASSERT_IMPL(a_prg_ram_range,
    rsp.valid && rsp.hit && rsp.region == lcbm_pkg::REGION_PRG_RAM, rsp.offset[16:13] == 4'd0)

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the latched CHR bank mapper: bus accesses, bank count, results.
`timescale 1ns / 1ps
module tb;

  // one bus access as the sender holds it
  typedef struct packed {
    lcbm_pkg::op_t op;
    logic [15:0]   addr;
    logic [7:0]    data;
  } access_t;

  typedef logic [lcbm_pkg::APB_ADDR_W-1:0] paddr_t;

  // byte address of the bank count register on the config port
  localparam paddr_t PRG_COUNT_ADDR = paddr_t'(4 * int'(lcbm_pkg::REG_PRG_BANK_COUNT));

  // CPU and PPU map boundaries
  localparam logic [15:0] CPU_RAM_BASE = 16'h6000;
  localparam logic [15:0] CPU_ROM_BASE = 16'h8000;
  localparam logic [15:0] CPU_WIN_BASE = 16'hA000;
  localparam logic [15:0] PPU_NT_BASE  = 16'h2000;
  localparam logic [15:0] PPU_NT_END   = 16'h3000;
  localparam int          PRG_WIN_BYTES = 8192;
  localparam int          CHR_WIN_BYTES = 4096;
  localparam int          NT_PAGE_BYTES = 1024;

  localparam int IDLE_PCT      = 19;
  localparam int ITEMS_PER_SET = 110;
  localparam int NUM_SETS      = 10;
  localparam int STEADY_SET    = 5;
  localparam int DRAIN_CYCLES  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [lcbm_pkg::APB_ADDR_W-1:0]     paddr;
  logic [lcbm_pkg::APB_DATA_W-1:0]     pwdata;
  logic [lcbm_pkg::APB_DATA_W-1:0]     prdata;
  logic                                pready;

  lcbm_req_if req_ch ();
  lcbm_rsp_if rsp_ch ();

  latched_chr_bank_mapper u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mapper state as the testbench sees it, advanced once per accepted access.
  lcbm_pkg::bank_file_t           bank_file;
  logic [1:0]                     chr_latch;
  logic [lcbm_pkg::COUNT_W-1:0]   prg_count;

  access_t              pending_q[$];   // accesses not yet transferred
  lcbm_pkg::xlate_res_t xlate_q[$];     // translations still owed by the block

  logic req_fire;
  logic steady;               // suppress all idling on both sides
  int   errors;
  int   op_count[4];
  int   results_seen;
  int   settings_applied;

  // Translate one access and advance bank registers and tile latches.
  function automatic lcbm_pkg::xlate_res_t translate_access(
      input lcbm_pkg::op_t op, input logic [15:0] addr, input logic [7:0] data);
    lcbm_pkg::xlate_res_t res;
    int         count;
    int         bank;
    int         slot;
    int         sel_reg;
    logic       half;
    logic       second;
    logic [7:0] tile;
    res = '0;
    if (prg_count < lcbm_pkg::PRG_COUNT_MIN) begin
      count = int'(lcbm_pkg::PRG_COUNT_MIN);
    end else if (prg_count > lcbm_pkg::PRG_COUNT_MAX) begin
      count = int'(lcbm_pkg::PRG_COUNT_MAX);
    end else begin
      count = int'(prg_count);
    end
    if (op == lcbm_pkg::OP_CPU_RD || op == lcbm_pkg::OP_CPU_WR) begin
      if (addr >= CPU_RAM_BASE && addr < CPU_ROM_BASE) begin
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_PRG_RAM;
        res.offset = 17'(addr - CPU_RAM_BASE);
      end else if (addr >= CPU_ROM_BASE && addr < CPU_WIN_BASE) begin
        // switched window wraps modulo the effective bank count
        bank       = int'(bank_file[lcbm_pkg::BANK_PRG][3:0]) % count;
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_PRG_ROM;
        res.offset = 17'(bank * PRG_WIN_BYTES + int'(addr[12:0]));
      end else if (addr >= CPU_WIN_BASE) begin
        // fixed windows map onto the last three banks
        slot       = (int'(addr) - int'(CPU_WIN_BASE)) >> 13;
        bank       = count - 3 + slot;
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_PRG_ROM;
        res.offset = 17'(bank * PRG_WIN_BYTES + int'(addr[12:0]));
      end
      if (op == lcbm_pkg::OP_CPU_WR && addr >= CPU_WIN_BASE) begin
        bank_file[addr[15:12] - lcbm_pkg::BANK_WIN_BASE] = data;
      end
    end else begin
      if (addr < PPU_NT_BASE) begin
        // translate with the latch as it stood before this access
        half       = addr[12];
        sel_reg    = int'(lcbm_pkg::BANK_CHR_LO) + 2 * int'(half) + int'(chr_latch[half]);
        bank       = int'(bank_file[sel_reg][4:0]);
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_CHR;
        res.offset = 17'(bank * CHR_WIN_BYTES + int'(addr[11:0]));
        if (op == lcbm_pkg::OP_PPU_RD) begin
          tile = addr[11:4];
          if (tile == lcbm_pkg::TILE_FD) begin
            chr_latch[half] = 1'b0;
          end else if (tile == lcbm_pkg::TILE_FE) begin
            chr_latch[half] = 1'b1;
          end
        end
      end else if (addr < PPU_NT_END) begin
        // bit 0 of the mirror register: 1 horizontal, 0 vertical
        second     = bank_file[lcbm_pkg::BANK_MIRROR][0] ? addr[11] : addr[10];
        res.hit    = 1'b1;
        res.region = lcbm_pkg::REGION_NT;
        res.offset = 17'(int'(addr[9:0]) + (second ? NT_PAGE_BYTES : 0));
      end
    end
    return res;
  endfunction

  // Bias addresses into the mapped windows and onto the latch tiles.
  function automatic access_t random_access();
    access_t a;
    a.op   = lcbm_pkg::op_t'($urandom_range(3));
    a.data = 8'($urandom_range(255));
    if (a.op == lcbm_pkg::OP_CPU_RD || a.op == lcbm_pkg::OP_CPU_WR) begin
      case ($urandom_range(3))
        0: a.addr = CPU_RAM_BASE + 16'($urandom_range(16'h1FFF));
        1: a.addr = CPU_ROM_BASE + 16'($urandom_range(16'h1FFF));
        2: a.addr = CPU_WIN_BASE + 16'($urandom_range(16'h5FFF));
        default: a.addr = 16'($urandom_range(16'hFFFF));
      endcase
    end else begin
      case ($urandom_range(3))
        0: a.addr = {3'b000, 1'($urandom_range(1)),
                     ($urandom_range(1) != 0) ? lcbm_pkg::TILE_FE : lcbm_pkg::TILE_FD,
                     4'($urandom_range(15))};
        1: a.addr = 16'($urandom_range(16'h1FFF));
        2: a.addr = PPU_NT_BASE + 16'($urandom_range(16'h0FFF));
        default: a.addr = 16'($urandom_range(16'hFFFF));
      endcase
    end
    return a;
  endfunction

  task automatic push_access(input lcbm_pkg::op_t op, input logic [15:0] addr,
                             input logic [7:0] data);
    access_t a;
    a.op   = op;
    a.addr = addr;
    a.data = data;
    pending_q.push_back(a);
  endtask

  // Hold until every access has gone in and every translation has come back.
  task automatic wait_drained();
    while (pending_q.size() != 0 || xlate_q.size() != 0) @(posedge clk);
  endtask

  // One config port transfer: setup cycle, then access cycle until pready.
  task automatic apb_xfer(input logic write, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= PRG_COUNT_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the bank count with junk above the field, then read it back.
  task automatic program_bank_count(input logic [lcbm_pkg::COUNT_W-1:0] value);
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic [31:0] want;
    wdata = ($urandom() & 32'hFFFF_FFE0) | 32'(value);
    apb_xfer(1'b1, wdata, rdata);
    prg_count = value;
    settings_applied++;
    want = 32'(value);
    apb_xfer(1'b0, 32'h0, rdata);
    if (rdata !== want) begin
      errors++;
      $display("%0t: bank count readback expected %0d actual %0d", $time, want, rdata);
    end
  endtask

  // Access side: on each transfer predict the translation and retire the access.
  always @(posedge clk) begin
    req_fire = !rst && req_ch.valid && req_ch.ready;
    if (req_fire) begin
      xlate_q.push_back(translate_access(lcbm_pkg::op_t'(req_ch.op), req_ch.addr,
                                         req_ch.data));
      op_count[req_ch.op]++;
      void'(pending_q.pop_front());
    end
  end

  // Drive at the falling edge: hold an offered access until it transfers,
  // otherwise offer the next one or idle. Stall the result side at random.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.op    <= '0;
      req_ch.addr  <= '0;
      req_ch.data  <= '0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (!(req_ch.valid && !req_fire)) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          req_ch.valid <= 1'b1;
          req_ch.op    <= pending_q[0].op;
          req_ch.addr  <= pending_q[0].addr;
          req_ch.data  <= pending_q[0].data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each transfer field by field with the oldest prediction.
  always @(posedge clk) begin : result_check
    lcbm_pkg::xlate_res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (xlate_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: hit %0d region %0d offset 0x%05h",
                 $time, rsp_ch.hit, rsp_ch.region, rsp_ch.offset);
      end else begin
        want = xlate_q.pop_front();
        if (rsp_ch.hit !== want.hit) begin
          errors++;
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_ch.hit);
        end
        if (rsp_ch.region !== want.region) begin
          errors++;
          $display("%0t: region expected %0d actual %0d", $time, want.region, rsp_ch.region);
        end
        if (rsp_ch.offset !== want.offset) begin
          errors++;
          $display("%0t: offset expected 0x%05h actual 0x%05h",
                   $time, want.offset, rsp_ch.offset);
        end
      end
    end
  end

  // Stimulus: directed accesses at reset settings, then random sets under
  // several bank counts, extremes and out-of-range values among them.
  initial begin : stimulus
    logic [lcbm_pkg::COUNT_W-1:0] count_plan[NUM_SETS];
    count_plan = '{5'd4, 5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'd9, 5'd13, 5'd5, 5'd7};
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    errors       = 0;
    results_seen = 0;
    settings_applied = 0;
    op_count     = '{0, 0, 0, 0};
    bank_file    = '0;
    chr_latch    = '0;
    prg_count    = lcbm_pkg::PRG_COUNT_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // CPU map edges, misses below PRG RAM
    push_access(lcbm_pkg::OP_CPU_RD, 16'h0000, 8'h00);
    push_access(lcbm_pkg::OP_CPU_RD, 16'h5FFF, 8'h00);
    push_access(lcbm_pkg::OP_CPU_WR, 16'h6000, 8'h00);
    push_access(lcbm_pkg::OP_CPU_RD, 16'h7FFF, 8'hFF);
    // load every bank register; PRG bank 15 wraps on small counts
    push_access(lcbm_pkg::OP_CPU_WR, 16'hA000, 8'hFF);
    push_access(lcbm_pkg::OP_CPU_RD, 16'h8000, 8'h00);
    push_access(lcbm_pkg::OP_CPU_RD, 16'h9FFF, 8'h00);
    push_access(lcbm_pkg::OP_CPU_WR, 16'hB000, 8'h5A);
    push_access(lcbm_pkg::OP_CPU_WR, 16'hC000, 8'hA5);
    push_access(lcbm_pkg::OP_CPU_WR, 16'hD000, 8'h1F);
    push_access(lcbm_pkg::OP_CPU_WR, 16'hE000, 8'hE0);
    push_access(lcbm_pkg::OP_CPU_WR, 16'hF000, 8'h01);
    // latch tiles in both halves: translate first, then flip
    push_access(lcbm_pkg::OP_PPU_RD, 16'h0000, 8'h00);
    push_access(lcbm_pkg::OP_PPU_RD, 16'h0FE0, 8'h00);
    push_access(lcbm_pkg::OP_PPU_RD, 16'h0123, 8'h00);
    push_access(lcbm_pkg::OP_PPU_WR, 16'h0FD0, 8'hFF);
    push_access(lcbm_pkg::OP_PPU_RD, 16'h0FDF, 8'h00);
    push_access(lcbm_pkg::OP_PPU_RD, 16'h1FE8, 8'h00);
    push_access(lcbm_pkg::OP_PPU_RD, 16'h1FFF, 8'h00);
    // nametables under horizontal mirroring, then PPU misses above them and a CPU hit at $FFFF
    push_access(lcbm_pkg::OP_PPU_RD, 16'h2000, 8'h00);
    push_access(lcbm_pkg::OP_PPU_RD, 16'h2BFF, 8'h00);
    push_access(lcbm_pkg::OP_PPU_WR, 16'h2FFF, 8'h00);
    push_access(lcbm_pkg::OP_PPU_RD, 16'h3000, 8'h00);
    push_access(lcbm_pkg::OP_PPU_RD, 16'hFFFF, 8'h00);
    push_access(lcbm_pkg::OP_CPU_RD, 16'hFFFF, 8'h00);
    wait_drained();

    for (int s = 0; s < NUM_SETS; s++) begin
      program_bank_count(count_plan[s]);
      // one set runs with no idling on either side
      steady = (s == STEADY_SET);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        pending_q.push_back(random_access());
      end
      wait_drained();
      steady = 1'b0;
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d cpu reads, %0d cpu writes,",
             results_seen, op_count[lcbm_pkg::OP_CPU_RD], op_count[lcbm_pkg::OP_CPU_WR]);
    $display("  %0d ppu reads, %0d ppu writes; bank count programmed %0d times, out of range too",
             op_count[lcbm_pkg::OP_PPU_RD], op_count[lcbm_pkg::OP_PPU_WR], settings_applied);
    if (errors == 0 && xlate_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
